// ===== sv/arpp_pkg.sv =====
// package with shared types and constants of the auto-ranging position tracker
`timescale 1ns / 1ps

package arpp_pkg;

  // window length and field widths
  localparam int SAMPLES_PER_RESULT = 16;
  localparam int CNT_W      = 9;
  localparam int ACC_W      = 20;
  localparam int MV_W       = 12;
  localparam int POS_W      = 14;
  localparam int CH_W       = 4;
  localparam int IDX_W      = 8;
  localparam int CFG_DATA_W = 12;

  // shared multiplier and divider sizes
  localparam int OP_W       = 14;
  localparam int MUL_W      = 26;
  localparam int DIV_STEPS  = MUL_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // scale constants
  localparam int MV_FULL_SCALE = 3300;
  localparam int POS_FULL      = 10000;

  // reset values of the configuration registers
  localparam logic [MV_W-1:0] RESET_MIN_MV = MV_W'(300);
  localparam logic [MV_W-1:0] RESET_MAX_MV = MV_W'(3000);

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_INIT_MIN = 8'd0,
    REG_INIT_MAX = 8'd1,
    REG_CHANNEL  = 8'd2
  } cfg_reg_e;

endpackage

// ===== sv/arpp_if.sv =====
// channel interfaces: sample input, result output and configuration write
`timescale 1ns / 1ps

interface arpp_in_if;
  import arpp_pkg::*;
  logic            valid;
  logic            ready;
  logic [MV_W-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

interface arpp_out_if;
  import arpp_pkg::*;
  logic             valid;
  logic             ready;
  logic [MV_W-1:0]  average_mv;
  logic [POS_W-1:0] position_hundredths;
  logic             range_valid;
  logic [MV_W-1:0]  seen_min_mv;
  logic [MV_W-1:0]  seen_max_mv;
  logic [CH_W-1:0]  source_channel;

  modport source (output valid, output average_mv, output position_hundredths,
                  output range_valid, output seen_min_mv, output seen_max_mv,
                  output source_channel, input ready);
  modport sink   (input valid, input average_mv, input position_hundredths,
                  input range_valid, input seen_min_mv, input seen_max_mv,
                  input source_channel, output ready);
endinterface

interface arpp_cfg_if;
  import arpp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [IDX_W-1:0]      reg_idx;
  logic [CFG_DATA_W-1:0] reg_data;

  modport source (output valid, output reg_idx, output reg_data, input ready);
  modport sink   (input valid, input reg_idx, input reg_data, output ready);
endinterface

// ===== sv/auto_ranging_position_percent.sv =====
// top level: sample averaging, min/max tracking and position by shared multiply and divide
// flow: a sample that does not close a window passes the accept, multiply and accumulate states;
// a window-closing sample then goes on through widen and numerator multiply to the restoring
// divider, one quotient bit per cycle, which is skipped when the tracked range is empty
// throughput: a new sample is taken only once the last is through; one result per window of 16 samples
// reset: async active low; bounds reload to 300/3000 mV, accumulator and count clear
`timescale 1ns / 1ps

module auto_ranging_position_percent (
  input  logic clk_i,
  input  logic rst_ni,
  arpp_in_if.sink    in_i,
  arpp_out_if.source res_o,
  arpp_cfg_if.sink   cfg_i
);
  import arpp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_WIDEN,
    ST_NUMER,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e                state_q;
  logic [MV_W-1:0]       raw_q;
  logic [MUL_W-1:0]      mul_q;
  logic [ACC_W-1:0]      acc_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [MV_W-1:0]       avg_q;
  logic [MV_W-1:0]       min_q;
  logic [MV_W-1:0]       max_q;
  logic [MV_W-1:0]       ini_min_q;
  logic [MV_W-1:0]       ini_max_q;
  logic [CH_W-1:0]       chan_q;
  logic                  rng_ok_q;
  logic [MUL_W-1:0]      div_num_q;
  logic [MV_W-1:0]       div_rem_q;
  logic [MV_W-1:0]       div_den_q;
  logic [DIV_CNT_W-1:0]  div_cnt_q;

  logic                  out_valid_q;
  logic [MV_W-1:0]       out_avg_q;
  logic [POS_W-1:0]      out_pos_q;
  logic                  out_rng_q;
  logic [MV_W-1:0]       out_min_q;
  logic [MV_W-1:0]       out_max_q;
  logic [CH_W-1:0]       out_chan_q;

  logic                  in_xfer;
  logic                  cfg_xfer;
  logic                  out_free;

  // shared multiplier: sample scaling or position numerator
  logic [OP_W-1:0]       mul_a;
  logic [OP_W-1:0]       mul_b;
  logic [2*OP_W-1:0]     mul_p;

  always_comb begin
    if (state_q == ST_NUMER) begin
      mul_a = OP_W'(avg_q - min_q);
      mul_b = OP_W'(POS_FULL);
    end else begin
      mul_a = OP_W'(raw_q);
      mul_b = OP_W'(MV_FULL_SCALE);
    end
  end

  assign mul_p = mul_a * mul_b;

  // divide by 4095 as (x + x/4096 + 1) / 4096, exact for this product range
  logic [MV_W+MV_W:0]    mv_sum;
  logic [MV_W-1:0]       mv;
  assign mv_sum = {1'b0, mul_q[2*MV_W-1:0]} + (2*MV_W+1)'(mul_q[2*MV_W-1:MV_W])
                + (2*MV_W+1)'(1);
  assign mv = mv_sum[2*MV_W-1:MV_W];

  // accumulate and window count
  logic [ACC_W-1:0]      acc_sum;
  logic [CNT_W-1:0]      cnt_inc;
  logic                  win_end;
  assign acc_sum = acc_q + ACC_W'(mv);
  assign cnt_inc = cnt_q + CNT_W'(1);
  assign win_end = (cnt_inc == CNT_W'(SAMPLES_PER_RESULT));

  // restoring divider step
  logic [MV_W:0]         rem_sh;
  logic [MV_W:0]         rem_sub;
  logic                  q_bit;
  assign rem_sh  = {div_rem_q, div_num_q[MUL_W-1]};
  assign rem_sub = rem_sh - {1'b0, div_den_q};
  assign q_bit   = (rem_sh >= {1'b0, div_den_q});

  // clamp quotient to full scale
  logic [POS_W-1:0]      pos_clamp;
  assign pos_clamp = (div_num_q > MUL_W'(POS_FULL)) ? POS_W'(POS_FULL)
                                                   : div_num_q[POS_W-1:0];

  // configuration decode with reload of the tracked bounds
  logic                  cfg_hit;
  logic [MV_W-1:0]       cfg_min;
  logic [MV_W-1:0]       cfg_max;
  logic [CH_W-1:0]       cfg_chan;

  always_comb begin
    cfg_hit  = 1'b0;
    cfg_min  = ini_min_q;
    cfg_max  = ini_max_q;
    cfg_chan = chan_q;
    case (cfg_i.reg_idx)
      REG_INIT_MIN: begin
        cfg_hit = 1'b1;
        cfg_min = cfg_i.reg_data[MV_W-1:0];
      end
      REG_INIT_MAX: begin
        cfg_hit = 1'b1;
        cfg_max = cfg_i.reg_data[MV_W-1:0];
      end
      REG_CHANNEL: begin
        cfg_hit  = 1'b1;
        cfg_chan = cfg_i.reg_data[CH_W-1:0];
      end
      default: begin
        cfg_hit = 1'b0;
      end
    endcase
  end

  assign in_xfer  = in_i.valid && in_i.ready;
  assign cfg_xfer = cfg_i.valid && cfg_i.ready;
  assign out_free = !out_valid_q || res_o.ready;

  // sequencer, datapath registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      cnt_q       <= '0;
      min_q       <= RESET_MIN_MV;
      max_q       <= RESET_MAX_MV;
      ini_min_q   <= RESET_MIN_MV;
      ini_max_q   <= RESET_MAX_MV;
      chan_q      <= '0;
      rng_ok_q    <= 1'b0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // result register valid: load on a finished window, clear on transfer
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            raw_q   <= in_i.raw_sample;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          mul_q   <= mul_p[MUL_W-1:0];
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          if (win_end) begin
            avg_q   <= MV_W'(acc_sum / SAMPLES_PER_RESULT);
            acc_q   <= '0;
            cnt_q   <= '0;
            state_q <= ST_WIDEN;
          end else begin
            acc_q   <= acc_sum;
            cnt_q   <= cnt_inc;
            state_q <= ST_IDLE;
          end
        end
        ST_WIDEN: begin
          if (avg_q < min_q) begin
            min_q <= avg_q;
          end
          if (avg_q > max_q) begin
            max_q <= avg_q;
          end
          state_q <= ST_NUMER;
        end
        ST_NUMER: begin
          rng_ok_q  <= (max_q > min_q);
          div_num_q <= mul_p[MUL_W-1:0];
          div_den_q <= max_q - min_q;
          div_rem_q <= '0;
          div_cnt_q <= '0;
          state_q   <= (max_q > min_q) ? ST_DIV : ST_DONE;
        end
        ST_DIV: begin
          div_num_q <= {div_num_q[MUL_W-2:0], q_bit};
          div_rem_q <= q_bit ? rem_sub[MV_W-1:0] : rem_sh[MV_W-1:0];
          div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
          if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_avg_q   <= avg_q;
            out_pos_q   <= rng_ok_q ? pos_clamp : '0;
            out_rng_q   <= rng_ok_q;
            out_min_q   <= min_q;
            out_max_q   <= max_q;
            out_chan_q  <= chan_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      // register write reloads the bounds and restarts the window
      if (cfg_xfer && cfg_hit) begin
        ini_min_q <= cfg_min;
        ini_max_q <= cfg_max;
        chan_q    <= cfg_chan;
        min_q     <= cfg_min;
        max_q     <= cfg_max;
        acc_q     <= '0;
        cnt_q     <= '0;
      end
    end
  end

  // port drive
  assign in_i.ready                = (state_q == ST_IDLE);
  assign cfg_i.ready               = 1'b1;
  assign res_o.valid               = out_valid_q;
  assign res_o.average_mv          = out_avg_q;
  assign res_o.position_hundredths = out_pos_q;
  assign res_o.range_valid         = out_rng_q;
  assign res_o.seen_min_mv         = out_min_q;
  assign res_o.seen_max_mv         = out_max_q;
  assign res_o.source_channel      = out_chan_q;

  // range flag agrees with the reported bounds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.range_valid == (res_o.seen_max_mv > res_o.seen_min_mv)))
    else $error("range flag disagrees with reported bounds");

  // empty range reports zero position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.range_valid) |-> (res_o.position_hundredths == '0))
    else $error("nonzero position on empty range");

  // position never above full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.position_hundredths <= POS_W'(POS_FULL)))
    else $error("position above full scale");

  // a sample transfer makes the block busy next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_i.ready)
    else $error("ready while a sample is in progress");

endmodule

// ===== tb/tb_auto_ranging_position_percent.sv =====
// self-checking testbench of the auto-ranging position tracker
`timescale 1ns / 1ps

module tb_auto_ranging_position_percent;
  import arpp_pkg::*;

  localparam int CLK_PERIOD     = 4;
  localparam int RAW_FULL_SCALE = 4095;
  localparam int DRAIN_CYCLES   = 64;
  localparam int CYCLE_LIMIT    = 600000;

  // indexes outside the register list, the block must ignore them
  localparam logic [IDX_W-1:0] REG_UNUSED     = 8'd7;
  localparam logic [IDX_W-1:0] REG_UNUSED_TOP = 8'hFF;

  // window shapes of the random stimulus
  typedef enum int {
    SHAPE_UNIFORM,
    SHAPE_CONSTANT,
    SHAPE_CLUSTER,
    SHAPE_ZERO,
    SHAPE_FULL
  } window_shape_e;

  typedef struct packed {
    logic [MV_W-1:0]  average_mv;
    logic [POS_W-1:0] position_hundredths;
    logic             range_valid;
    logic [MV_W-1:0]  seen_min_mv;
    logic [MV_W-1:0]  seen_max_mv;
    logic [CH_W-1:0]  source_channel;
  } window_result_t;

  // tracks averaging and min/max ranging, holds the expected window results
  class position_scoreboard;
    bit [MV_W-1:0]  init_min;
    bit [MV_W-1:0]  init_max;
    bit [CH_W-1:0]  chan;
    bit [ACC_W-1:0] mv_sum;
    bit [CNT_W-1:0] win_fill;
    bit [MV_W-1:0]  lo;
    bit [MV_W-1:0]  hi;
    window_result_t window_q[$];
    int             errors;

    function new();
      init_min = RESET_MIN_MV;
      init_max = RESET_MAX_MV;
      chan     = '0;
      errors   = 0;
      reload();
    endfunction

    function void reload();
      lo       = init_min;
      hi       = init_max;
      mv_sum   = '0;
      win_fill = '0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_INIT_MIN: init_min = data[MV_W-1:0];
        REG_INIT_MAX: init_max = data[MV_W-1:0];
        REG_CHANNEL:  chan = data[CH_W-1:0];
        default:      return;
      endcase
      reload();
    endfunction

    // accepted sample: accumulate, and on a full window widen and place
    function void note_sample(logic [MV_W-1:0] raw);
      int unsigned    mv;
      int unsigned    avg;
      int unsigned    span;
      int unsigned    pos;
      window_result_t r;
      mv = (32'(raw) * MV_FULL_SCALE) / RAW_FULL_SCALE;
      mv_sum = mv_sum + ACC_W'(mv);
      win_fill = win_fill + 1'b1;
      if (win_fill < SAMPLES_PER_RESULT) return;
      avg = mv_sum / SAMPLES_PER_RESULT;
      mv_sum = '0;
      win_fill = '0;
      if (avg < lo) lo = MV_W'(avg);
      if (avg > hi) hi = MV_W'(avg);
      pos = 0;
      r.range_valid = 1'b0;
      if (hi > lo) begin
        span = hi - lo;
        pos = ((avg - lo) * POS_FULL) / span;
        if (pos > POS_FULL) pos = POS_FULL;
        r.range_valid = 1'b1;
      end
      r.average_mv          = MV_W'(avg);
      r.position_hundredths = POS_W'(pos);
      r.seen_min_mv         = lo;
      r.seen_max_mv         = hi;
      r.source_channel      = chan;
      window_q.push_back(r);
    endfunction

    function void check_result(window_result_t got);
      window_result_t exp;
      if (window_q.size() == 0) begin
        $error("unexpected result transfer, average_mv %0d", got.average_mv);
        errors++;
        return;
      end
      exp = window_q.pop_front();
      if (got.average_mv !== exp.average_mv) begin
        $error("average_mv: expected %0d, actual %0d", exp.average_mv, got.average_mv);
        errors++;
      end
      if (got.position_hundredths !== exp.position_hundredths) begin
        $error("position_hundredths: expected %0d, actual %0d",
               exp.position_hundredths, got.position_hundredths);
        errors++;
      end
      if (got.range_valid !== exp.range_valid) begin
        $error("range_valid: expected %0d, actual %0d", exp.range_valid, got.range_valid);
        errors++;
      end
      if (got.seen_min_mv !== exp.seen_min_mv) begin
        $error("seen_min_mv: expected %0d, actual %0d", exp.seen_min_mv, got.seen_min_mv);
        errors++;
      end
      if (got.seen_max_mv !== exp.seen_max_mv) begin
        $error("seen_max_mv: expected %0d, actual %0d", exp.seen_max_mv, got.seen_max_mv);
        errors++;
      end
      if (got.source_channel !== exp.source_channel) begin
        $error("source_channel: expected %0d, actual %0d",
               exp.source_channel, got.source_channel);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  arpp_in_if  in_ch ();
  arpp_out_if res_ch ();
  arpp_cfg_if cfg_ch ();

  auto_ranging_position_percent dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  position_scoreboard sb = new();

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          cycle_cnt = 0;
  int          win_shape;
  int unsigned shape_base;

  // clock
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_auto_ranging_position_percent: done, errors");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // result monitor: every transfer is checked against the oldest expectation
  always @(posedge clk_i) begin : result_monitor
    window_result_t got;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got.average_mv          = res_ch.average_mv;
      got.position_hundredths = res_ch.position_hundredths;
      got.range_valid         = res_ch.range_valid;
      got.seen_min_mv         = res_ch.seen_min_mv;
      got.seen_max_mv         = res_ch.seen_max_mv;
      got.source_channel      = res_ch.source_channel;
      sb.check_result(got);
    end
  end

  // one sample transfer, valid stays high for the caller to lower or reuse
  task automatic send_sample(logic [MV_W-1:0] raw);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.raw_sample <= raw;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_sample(raw);
    @(negedge clk_i);
  endtask

  // one register write transfer, valid stays high for the caller to lower or reuse
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.reg_idx  <= idx;
    cfg_ch.reg_data <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  // hold the sender until every expected result has arrived
  task automatic drain_results(int extra);
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.window_q.size() != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  // reprogram the bounds and the channel once the block is idle
  task automatic program_tracker(logic [CFG_DATA_W-1:0] min_mv,
                                 logic [CFG_DATA_W-1:0] max_mv,
                                 logic [CFG_DATA_W-1:0] chan);
    drain_results(DRAIN_CYCLES);
    write_reg(REG_INIT_MIN, min_mv);
    write_reg(REG_INIT_MAX, max_mv);
    write_reg(REG_CHANNEL, chan);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // random windows: each window gets a shape, its samples follow it
  task automatic run_windows(int n_items);
    int raw;
    for (int i = 0; i < n_items; i++) begin
      if (sb.win_fill == 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2: win_shape = SHAPE_UNIFORM;
          3, 4:    win_shape = SHAPE_CONSTANT;
          5, 6, 7: win_shape = SHAPE_CLUSTER;
          8:       win_shape = SHAPE_ZERO;
          default: win_shape = SHAPE_FULL;
        endcase
        shape_base = $urandom_range(0, RAW_FULL_SCALE);
      end
      case (win_shape)
        SHAPE_UNIFORM:  raw = $urandom_range(0, RAW_FULL_SCALE);
        SHAPE_CONSTANT: raw = shape_base;
        SHAPE_CLUSTER: begin
          raw = int'(shape_base) + int'($urandom_range(0, 128)) - 64;
          if (raw < 0) raw = 0;
          if (raw > RAW_FULL_SCALE) raw = RAW_FULL_SCALE;
        end
        SHAPE_ZERO:     raw = 0;
        default:        raw = RAW_FULL_SCALE;
      endcase
      send_sample(MV_W'(raw));
      if ($urandom_range(0, 199) == 0) drain_results(0);
    end
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  initial begin
    logic [MV_W-1:0] corner_raws [9] = '{12'd0, 12'd4095, 12'hAAA, 12'h555, 12'd1,
                                         12'h800, 12'h7FF, 12'd2048, 12'd4094};
    in_ch.valid      = 1'b0;
    in_ch.raw_sample = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_idx   = '0;
    cfg_ch.reg_data  = '0;
    res_ch.ready     = 1'b0;
    rst_ni           = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset bounds: a full-scale window widens the maximum, then corner samples
    set_idling(8, 86);
    repeat (SAMPLES_PER_RESULT) send_sample(MV_W'(RAW_FULL_SCALE));
    foreach (corner_raws[i]) send_sample(corner_raws[i]);
    drain_results(0);
    run_windows(220);

    // widest bounds, channel 9
    program_tracker(12'd0, 12'd4095, 12'd9);
    run_windows(260);

    // crossed bounds, ignored indexes in between
    set_idling(86, 8);
    program_tracker(12'd3300, 12'd0, 12'd15);
    write_reg(REG_UNUSED, 12'hFFF);
    write_reg(REG_UNUSED_TOP, 12'h000);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
    run_windows(260);

    // equal bounds at zero: a zero window leaves the range empty
    program_tracker(12'd0, 12'd0, 12'd0);
    repeat (SAMPLES_PER_RESULT) send_sample('0);
    run_windows(260);

    // random bounds, channel from wide write data
    set_idling(0, 0);
    program_tracker(CFG_DATA_W'($urandom_range(0, 4095)), CFG_DATA_W'($urandom_range(0, 4095)),
                    CFG_DATA_W'($urandom_range(0, 4095)));
    run_windows(300);

    // bounds above full scale
    program_tracker(12'd4095, 12'd4095, 12'hFF9);
    run_windows(340);

    drain_results(DRAIN_CYCLES);
    if (sb.window_q.size() != 0) begin
      $error("%0d expected results never arrived", sb.window_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("tb_auto_ranging_position_percent: done, clean");
    end else begin
      $display("tb_auto_ranging_position_percent: done, errors");
    end
    $finish;
  end

endmodule
